// ===== rtl/core/rc2_block_cipher_with_key_expansion_unit_macros.svh =====
// Assertion macros used by the RC2 engine checker.
`ifndef RC2_BLOCK_CIPHER_WITH_KEY_EXPANSION_UNIT_MACROS_SVH
`define RC2_BLOCK_CIPHER_WITH_KEY_EXPANSION_UNIT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define RC2_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rc2 same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define RC2_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rc2 next-cycle check failed");

`endif

// ===== rtl/core/rc2_pkg.sv =====
// Shared types, constants and tables of the RC2 cipher engine.
`default_nettype none

package rc2_pkg;

  // Key store depth and derived limits
  localparam int EXP_BYTES = 128;
  localparam logic [7:0]  KEY_LEN_MAX    = 8'(EXP_BYTES);
  localparam logic [10:0] EFF_BITS_MAX   = 11'(8 * EXP_BYTES);
  localparam logic [7:0]  KEY_LEN_RESET  = 8'd16;
  localparam logic [10:0] EFF_BITS_RESET = 11'(8 * EXP_BYTES);
  localparam logic [7:0]  LAST_IDX       = 8'(EXP_BYTES - 1);

  // Round schedule: mashing follows the 5th and 11th mixing rounds
  localparam logic [3:0] MASH_AFTER_A = 4'd4;
  localparam logic [3:0] MASH_AFTER_B = 4'd10;
  localparam logic [3:0] LAST_ROUND   = 4'd15;

  typedef enum logic [1:0] {
    CMD_LOAD_KEY = 2'd0,
    CMD_EXPAND   = 2'd1,
    CMD_ENCRYPT  = 2'd2,
    CMD_DECRYPT  = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_KEY_LEN  = 1'b0,
    REG_EFF_BITS = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_MIX,
    ST_MASH_RD,
    ST_MASH,
    ST_DONE
  } blk_state_t;

  typedef enum logic [3:0] {
    KX_IDLE,
    KX_COPY_RD,
    KX_COPY_WR,
    KX_FWD_RD,
    KX_FWD_WR,
    KX_MASK_RD,
    KX_MASK_WR,
    KX_BACK_RD,
    KX_BACK_WR,
    KX_OUT_RD,
    KX_OUT_WR
  } kx_state_t;

  // Requests from the block control to the key expansion unit
  typedef struct packed {
    logic        key_we;
    logic [6:0]  key_idx;
    logic [7:0]  key_byte;
    logic        start;
    logic [7:0]  key_len;
    logic [10:0] eff_bits;
  } kx_req_t;

  // Subkey row writes and completion from the key expansion unit
  typedef struct packed {
    logic        we;
    logic [3:0]  row;
    logic [63:0] data;
    logic        done;
  } kx_rsp_t;

  // Rotation per word position
  localparam logic [2:0] ROT_AMT [4] = '{3'd1, 3'd2, 3'd3, 3'd5};

  // Byte substitution table derived from the digits of pi
  localparam logic [7:0] PI_TABLE [256] = '{
    8'hd9, 8'h78, 8'hf9, 8'hc4, 8'h19, 8'hdd, 8'hb5, 8'hed,
    8'h28, 8'he9, 8'hfd, 8'h79, 8'h4a, 8'ha0, 8'hd8, 8'h9d,
    8'hc6, 8'h7e, 8'h37, 8'h83, 8'h2b, 8'h76, 8'h53, 8'h8e,
    8'h62, 8'h4c, 8'h64, 8'h88, 8'h44, 8'h8b, 8'hfb, 8'ha2,
    8'h17, 8'h9a, 8'h59, 8'hf5, 8'h87, 8'hb3, 8'h4f, 8'h13,
    8'h61, 8'h45, 8'h6d, 8'h8d, 8'h09, 8'h81, 8'h7d, 8'h32,
    8'hbd, 8'h8f, 8'h40, 8'heb, 8'h86, 8'hb7, 8'h7b, 8'h0b,
    8'hf0, 8'h95, 8'h21, 8'h22, 8'h5c, 8'h6b, 8'h4e, 8'h82,
    8'h54, 8'hd6, 8'h65, 8'h93, 8'hce, 8'h60, 8'hb2, 8'h1c,
    8'h73, 8'h56, 8'hc0, 8'h14, 8'ha7, 8'h8c, 8'hf1, 8'hdc,
    8'h12, 8'h75, 8'hca, 8'h1f, 8'h3b, 8'hbe, 8'he4, 8'hd1,
    8'h42, 8'h3d, 8'hd4, 8'h30, 8'ha3, 8'h3c, 8'hb6, 8'h26,
    8'h6f, 8'hbf, 8'h0e, 8'hda, 8'h46, 8'h69, 8'h07, 8'h57,
    8'h27, 8'hf2, 8'h1d, 8'h9b, 8'hbc, 8'h94, 8'h43, 8'h03,
    8'hf8, 8'h11, 8'hc7, 8'hf6, 8'h90, 8'hef, 8'h3e, 8'he7,
    8'h06, 8'hc3, 8'hd5, 8'h2f, 8'hc8, 8'h66, 8'h1e, 8'hd7,
    8'h08, 8'he8, 8'hea, 8'hde, 8'h80, 8'h52, 8'hee, 8'hf7,
    8'h84, 8'haa, 8'h72, 8'hac, 8'h35, 8'h4d, 8'h6a, 8'h2a,
    8'h96, 8'h1a, 8'hd2, 8'h71, 8'h5a, 8'h15, 8'h49, 8'h74,
    8'h4b, 8'h9f, 8'hd0, 8'h5e, 8'h04, 8'h18, 8'ha4, 8'hec,
    8'hc2, 8'he0, 8'h41, 8'h6e, 8'h0f, 8'h51, 8'hcb, 8'hcc,
    8'h24, 8'h91, 8'haf, 8'h50, 8'ha1, 8'hf4, 8'h70, 8'h39,
    8'h99, 8'h7c, 8'h3a, 8'h85, 8'h23, 8'hb8, 8'hb4, 8'h7a,
    8'hfc, 8'h02, 8'h36, 8'h5b, 8'h25, 8'h55, 8'h97, 8'h31,
    8'h2d, 8'h5d, 8'hfa, 8'h98, 8'he3, 8'h8a, 8'h92, 8'hae,
    8'h05, 8'hdf, 8'h29, 8'h10, 8'h67, 8'h6c, 8'hba, 8'hc9,
    8'hd3, 8'h00, 8'he6, 8'hcf, 8'he1, 8'h9e, 8'ha8, 8'h2c,
    8'h63, 8'h16, 8'h01, 8'h3f, 8'h58, 8'he2, 8'h89, 8'ha9,
    8'h0d, 8'h38, 8'h34, 8'h1b, 8'hab, 8'h33, 8'hff, 8'hb0,
    8'hbb, 8'h48, 8'h0c, 8'h5f, 8'hb9, 8'hb1, 8'hcd, 8'h2e,
    8'hc5, 8'hf3, 8'hdb, 8'h47, 8'he5, 8'ha5, 8'h9c, 8'h77,
    8'h0a, 8'ha6, 8'h20, 8'h68, 8'hfe, 8'h7f, 8'hc1, 8'had
  };

  function automatic logic [7:0] rc2_pi(input logic [7:0] x);
    return PI_TABLE[x];
  endfunction

  function automatic logic [15:0] rotl16(input logic [15:0] x, input logic [2:0] s);
    logic [31:0] w;
    w = {x, x} << s;
    return w[31:16];
  endfunction

  function automatic logic [15:0] rotr16(input logic [15:0] x, input logic [2:0] s);
    logic [31:0] w;
    w = {x, x} >> s;
    return w[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rc2_req_if.sv =====
// Command channel of the RC2 engine: valid, ready and one command item.
`default_nettype none

interface rc2_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [6:0]  key_index;
  logic [7:0]  key_byte;
  logic [63:0] block_in;

  modport source (output valid, cmd, key_index, key_byte, block_in, input ready);
  modport sink   (input valid, cmd, key_index, key_byte, block_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rc2_rsp_if.sv =====
// Result channel of the RC2 engine: valid, ready and one result block.
`default_nettype none

interface rc2_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out;

  modport source (output valid, block_out, input ready);
  modport sink   (input valid, block_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rc2_cfg_if.sv =====
// Configuration write channel of the RC2 engine.
`default_nettype none

interface rc2_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [10:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rc2_kexp.sv =====
// RC2 key store and key expansion sequencer that fills the subkey table.
`default_nettype none

module rc2_kexp (
  input  logic             clk,
  input  logic             rst,
  input  rc2_pkg::kx_req_t req,
  output rc2_pkg::kx_rsp_t rsp
);
  import rc2_pkg::*;

  kx_state_t   state, state_next;

  // User key store and scratch expansion buffer
  logic [7:0]  key_mem [EXP_BYTES];
  logic [7:0]  scr_mem [EXP_BYTES];
  logic [7:0]  ks_q;
  logic [7:0]  scr_q;
  logic [6:0]  ks_raddr;
  logic [6:0]  scr_raddr;
  logic        scr_we;
  logic [6:0]  scr_waddr;
  logic [7:0]  scr_wdata;

  // Expansion parameters latched at start
  logic [7:0]  t_len;
  logic [7:0]  t8;
  logic [7:0]  tm;
  logic [7:0]  t_len_c;
  logic [10:0] eff_c;
  logic [7:0]  t8_c;
  logic [7:0]  tm_c;
  logic [2:0]  tm_sh;
  logic        par_load;

  logic [7:0]  idx, idx_next;
  logic [7:0]  prev, prev_next;
  logic [63:0] row_acc;
  logic        acc_we;
  logic [7:0]  mask_pos;
  logic [7:0]  pi_in;
  logic [7:0]  pi_out;

  // Clamp key length and effective bits, derive byte count and top mask
  always_comb begin
    if (req.key_len == 8'd0) begin
      t_len_c = 8'd1;
    end else if (req.key_len > KEY_LEN_MAX) begin
      t_len_c = KEY_LEN_MAX;
    end else begin
      t_len_c = req.key_len;
    end
    if (req.eff_bits == 11'd0) begin
      eff_c = 11'd1;
    end else if (req.eff_bits > EFF_BITS_MAX) begin
      eff_c = EFF_BITS_MAX;
    end else begin
      eff_c = req.eff_bits;
    end
    t8_c  = 8'((12'(eff_c) + 12'd7) >> 3);
    tm_sh = 3'(4'd8 - {1'b0, eff_c[2:0]});
    tm_c  = 8'hff >> tm_sh;
  end

  assign mask_pos = KEY_LEN_MAX - t8;
  assign pi_out   = rc2_pi(pi_in);

  // Key store: written by load commands, read during the copy pass
  always_ff @(posedge clk) begin
    if (req.key_we) begin
      key_mem[req.key_idx] <= req.key_byte;
    end
    ks_q <= key_mem[ks_raddr];
  end

  // Scratch buffer: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
    scr_q <= scr_mem[scr_raddr];
  end

  // Hold state, counters and parameters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= KX_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    prev <= prev_next;
    if (par_load) begin
      t_len <= t_len_c;
      t8    <= t8_c;
      tm    <= tm_c;
    end
    if (acc_we) begin
      row_acc[8*idx[2:0] +: 8] <= scr_q;
    end
  end

  // Sequence the copy, forward, mask, backward and unload passes
  always_comb begin
    state_next = state;
    idx_next   = idx;
    prev_next  = prev;
    par_load   = 1'b0;
    acc_we     = 1'b0;
    ks_raddr   = idx[6:0];
    scr_raddr  = idx[6:0];
    scr_we     = 1'b0;
    scr_waddr  = idx[6:0];
    scr_wdata  = pi_out;
    pi_in      = prev + scr_q;
    rsp        = '0;

    unique case (state)
      KX_IDLE: begin
        if (req.start) begin
          par_load   = 1'b1;
          idx_next   = '0;
          state_next = KX_COPY_RD;
        end
      end
      KX_COPY_RD: begin
        state_next = KX_COPY_WR;
      end
      KX_COPY_WR: begin
        scr_we    = 1'b1;
        scr_wdata = ks_q;
        prev_next = ks_q;
        idx_next  = idx + 8'd1;
        if (idx + 8'd1 == t_len) begin
          state_next = (t_len == KEY_LEN_MAX) ? KX_MASK_RD : KX_FWD_RD;
        end else begin
          state_next = KX_COPY_RD;
        end
      end
      KX_FWD_RD: begin
        scr_raddr  = 7'(idx - t_len);
        state_next = KX_FWD_WR;
      end
      KX_FWD_WR: begin
        pi_in     = prev + scr_q;
        scr_we    = 1'b1;
        prev_next = pi_out;
        idx_next  = idx + 8'd1;
        state_next = (idx == LAST_IDX) ? KX_MASK_RD : KX_FWD_RD;
      end
      KX_MASK_RD: begin
        scr_raddr  = mask_pos[6:0];
        state_next = KX_MASK_WR;
      end
      KX_MASK_WR: begin
        pi_in     = scr_q & tm;
        scr_we    = 1'b1;
        scr_waddr = mask_pos[6:0];
        prev_next = pi_out;
        if (mask_pos == 8'd0) begin
          idx_next   = '0;
          state_next = KX_OUT_RD;
        end else begin
          idx_next   = mask_pos - 8'd1;
          state_next = KX_BACK_RD;
        end
      end
      KX_BACK_RD: begin
        scr_raddr  = 7'(idx + t8);
        state_next = KX_BACK_WR;
      end
      KX_BACK_WR: begin
        pi_in     = prev ^ scr_q;
        scr_we    = 1'b1;
        prev_next = pi_out;
        if (idx == 8'd0) begin
          state_next = KX_OUT_RD;
        end else begin
          idx_next   = idx - 8'd1;
          state_next = KX_BACK_RD;
        end
      end
      KX_OUT_RD: begin
        state_next = KX_OUT_WR;
      end
      KX_OUT_WR: begin
        acc_we = 1'b1;
        // Emit a subkey row once its eighth byte arrives
        if (idx[2:0] == 3'd7) begin
          rsp.we   = 1'b1;
          rsp.row  = idx[6:3];
          rsp.data = {scr_q, row_acc[55:0]};
        end
        if (idx == LAST_IDX) begin
          rsp.done   = 1'b1;
          idx_next   = '0;
          state_next = KX_IDLE;
        end else begin
          idx_next   = idx + 8'd1;
          state_next = KX_OUT_RD;
        end
      end
      default: begin
        state_next = KX_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rc2_block_cipher_with_key_expansion_unit.sv =====
// Top level of the RC2 cipher engine: command decode, block rounds, subkey table.
`default_nettype none

// RC2 engine with on-chip key expansion. Command 0 stores one key byte;
// command 1 expands the first key_length_bytes stored bytes (limited by
// effective_key_bits) into the 64-word subkey table in copy, forward, mask,
// backward and unload passes, each byte being read through the registered
// scratch buffer read before it is rewritten. Commands 2 and 3 encrypt or
// decrypt one block, with the first byte as most significant and the four
// 16-bit words in big-endian order; a block passes through sixteen mixing
// rounds and two mashing rounds before it reaches the output register, each
// mashing round waiting on the registered subkey table read because each
// subkey address comes from the word just updated, and a final state writes
// the result back. The next item is accepted only after that write back.
// A result waits in the output register while the next item is accepted.
// The subkey table reads as zero until the first expansion finishes.
// Configuration writes are always accepted.
module rc2_block_cipher_with_key_expansion_unit (
  input logic        clk,
  input logic        rst,
  rc2_req_if.sink    req,
  rc2_rsp_if.source  rsp,
  rc2_cfg_if.sink    cfg
);
  import rc2_pkg::*;

  blk_state_t  state, state_next;

  logic [7:0]  key_len;
  logic [10:0] eff_bits;

  // Round state
  logic [15:0] r [4];
  logic [15:0] mix_r [4];
  logic [15:0] r_upd [4];
  logic [3:0]  rnd;
  logic        dec;
  logic [1:0]  mw;
  logic [1:0]  msel;

  // Subkey table: 16 rows of four words, registered read
  logic [63:0] sk_mem [16];
  logic [63:0] sk_q;
  logic [63:0] sk_row;
  logic [3:0]  sk_raddr;
  logic        loaded;

  logic [63:0] out_data;
  logic        out_valid;

  kx_req_t     kx_req;
  kx_rsp_t     kx_rsp;

  logic        req_ready;
  logic        blk_load;
  logic        mix_en;
  logic        mash_setup;
  logic        mash_en;
  logic        out_load;
  logic        is_dec_cmd;

  logic [15:0] mash_w;
  logic [1:0]  mw_first;
  logic [1:0]  mw_nx;
  logic        mash_last;
  logic [5:0]  setup_addr;
  logic [5:0]  nxt_addr;

  rc2_kexp u_kexp (
    .clk (clk),
    .rst (rst),
    .req (kx_req),
    .rsp (kx_rsp)
  );

  assign req.ready     = req_ready;
  assign rsp.valid     = out_valid;
  assign rsp.block_out = out_data;
  assign cfg.ready     = 1'b1;

  assign is_dec_cmd = (cmd_t'(req.cmd) == CMD_DECRYPT);
  assign sk_row     = loaded ? sk_q : '0;

  // Store configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_len  <= KEY_LEN_RESET;
      eff_bits <= EFF_BITS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_KEY_LEN:  key_len  <= cfg.data[7:0];
        REG_EFF_BITS: eff_bits <= cfg.data;
        default:      key_len  <= key_len;
      endcase
    end
  end

  // Subkey table: rows written by expansion, one row read per cycle
  always_ff @(posedge clk) begin
    if (kx_rsp.we) begin
      sk_mem[kx_rsp.row] <= kx_rsp.data;
    end
    sk_q <= sk_mem[sk_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
    end else if (kx_rsp.done) begin
      loaded <= 1'b1;
    end
  end

  // One mixing round, forward or inverse, over the current row of subkeys
  always_comb begin
    logic [1:0]  ib;
    logic [15:0] a, b, c, k, x;
    mix_r = r;
    for (int n = 0; n < 4; n++) begin
      ib = dec ? 2'(3 - n) : 2'(n);
      a  = mix_r[ib + 2'd3];
      b  = mix_r[ib + 2'd2];
      c  = mix_r[ib + 2'd1];
      k  = sk_row[16*ib +: 16];
      if (dec) begin
        x         = rotr16(mix_r[ib], ROT_AMT[ib]);
        mix_r[ib] = x - k - (a & b) - (~a & c);
      end else begin
        x         = mix_r[ib] + k + (a & b) + (~a & c);
        mix_r[ib] = rotl16(x, ROT_AMT[ib]);
      end
    end
  end

  // One mashing word per cycle; the next address comes from updated words
  always_comb begin
    mash_w    = sk_row[16*msel +: 16];
    r_upd     = r;
    r_upd[mw] = dec ? (r[mw] - mash_w) : (r[mw] + mash_w);
    mw_first  = dec ? 2'd3 : 2'd0;
    mw_nx     = dec ? (mw - 2'd1) : (mw + 2'd1);
    mash_last = dec ? (mw == 2'd0) : (mw == 2'd3);
    setup_addr = r[mw_first + 2'd3][5:0];
    nxt_addr   = r_upd[mw_nx + 2'd3][5:0];
  end

  // Control state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, subkey read address and datapath strobes
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    blk_load   = 1'b0;
    mix_en     = 1'b0;
    mash_setup = 1'b0;
    mash_en    = 1'b0;
    out_load   = 1'b0;
    sk_raddr   = rnd ^ {4{dec}};

    kx_req          = '0;
    kx_req.key_idx  = req.key_index;
    kx_req.key_byte = req.key_byte;
    kx_req.key_len  = key_len;
    kx_req.eff_bits = eff_bits;

    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) begin
          unique case (cmd_t'(req.cmd))
            CMD_LOAD_KEY: begin
              kx_req.key_we = 1'b1;
            end
            CMD_EXPAND: begin
              kx_req.start = 1'b1;
              state_next   = ST_KEXP;
            end
            CMD_ENCRYPT, CMD_DECRYPT: begin
              blk_load   = 1'b1;
              sk_raddr   = {4{is_dec_cmd}};
              state_next = ST_MIX;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_KEXP: begin
        if (kx_rsp.done) begin
          state_next = ST_IDLE;
        end
      end
      ST_MIX: begin
        mix_en = 1'b1;
        if (rnd == MASH_AFTER_A || rnd == MASH_AFTER_B) begin
          state_next = ST_MASH_RD;
        end else if (rnd == LAST_ROUND) begin
          state_next = ST_DONE;
        end else begin
          sk_raddr = (rnd + 4'd1) ^ {4{dec}};
        end
      end
      ST_MASH_RD: begin
        mash_setup = 1'b1;
        sk_raddr   = setup_addr[5:2];
        state_next = ST_MASH;
      end
      ST_MASH: begin
        mash_en = 1'b1;
        if (mash_last) begin
          state_next = ST_MIX;
        end else begin
          sk_raddr = nxt_addr[5:2];
        end
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Round counter and direction
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
      dec <= 1'b0;
    end else if (blk_load) begin
      rnd <= '0;
      dec <= is_dec_cmd;
    end else if (mix_en) begin
      rnd <= rnd + 4'd1;
    end
  end

  // Round words and mashing word pointer
  always_ff @(posedge clk) begin
    if (blk_load) begin
      r[0] <= req.block_in[63:48];
      r[1] <= req.block_in[47:32];
      r[2] <= req.block_in[31:16];
      r[3] <= req.block_in[15:0];
    end else if (mix_en) begin
      r <= mix_r;
    end else if (mash_en) begin
      r <= r_upd;
    end
    if (mash_setup) begin
      mw   <= mw_first;
      msel <= setup_addr[1:0];
    end else if (mash_en) begin
      mw   <= mw_nx;
      msel <= nxt_addr[1:0];
    end
  end

  // Output register: hold a result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {r[0], r[1], r[2], r[3]};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rc2_chk.sv =====
// Port-level checker for the RC2 engine and its bind to the top level.
`default_nettype none
`include "rc2_block_cipher_with_key_expansion_unit_macros.svh"

module rc2_chk (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  req_cmd,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [63:0] rsp_block_out
);
  import rc2_pkg::*;

  // A stalled result keeps its value
  `RC2_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_block_out))

  // A block item keeps the engine busy in the next cycle
  `RC2_ASSERT_NEXT(a_block_busy, req_valid && req_ready && (req_cmd == CMD_ENCRYPT || req_cmd == CMD_DECRYPT), !req_ready)

  // Key expansion keeps the engine busy in the next cycle
  `RC2_ASSERT_NEXT(a_expand_busy, req_valid && req_ready && req_cmd == CMD_EXPAND, !req_ready)

  // A key byte load leaves the engine ready
  `RC2_ASSERT_NEXT(a_load_ready, req_valid && req_ready && req_cmd == CMD_LOAD_KEY, req_ready)

  // A new result only appears at the end of block work
  `RC2_ASSERT_SAME(a_rsp_from_block, $rose(rsp_valid), !$past(req_ready))

endmodule

bind rc2_block_cipher_with_key_expansion_unit rc2_chk u_rc2_chk (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_cmd       (req.cmd),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_block_out (rsp.block_out)
);

`default_nettype wire
